// File: sv/swad_pkg.sv
`default_nettype none
package swad_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // configuration register widths
  localparam int WLEN_W = 5;
  localparam int MSL_W  = 24;
  localparam int RPT_W  = 5;
  localparam int JMP_W  = 16;

  // result field widths
  localparam int MEAN_W    = 24;
  localparam int TOTAL_W   = 32;
  localparam int FRAC_BITS = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH    = 2'd0,
    REG_MEAN_SHIFT_LIMIT = 2'd1,
    REG_REPEAT_LIMIT     = 2'd2,
    REG_JUMP_LIMIT       = 2'd3
  } cfg_reg_t;

  localparam logic [WLEN_W-1:0] WLEN_RESET = 5'd5;
  localparam logic [MSL_W-1:0]  MSL_RESET  = 24'd2560;
  localparam logic [RPT_W-1:0]  RPT_RESET  = 5'd3;
  localparam logic [JMP_W-1:0]  JMP_RESET  = 16'd15;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage
`default_nettype wire

// File: sv/swad_if.sv
`default_nettype none
interface swad_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface swad_out_if import swad_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     anomaly;
  logic                     mean_shift;
  logic                     high_repeat;
  logic                     jump;
  logic signed [MEAN_W-1:0] window_mean;
  logic [TOTAL_W-1:0]       anomaly_total;

  modport source (
    output valid, output anomaly, output mean_shift, output high_repeat,
    output jump, output window_mean, output anomaly_total, input ready
  );
  modport sink (
    input valid, input anomaly, input mean_shift, input high_repeat,
    input jump, input window_mean, input anomaly_total, output ready
  );
endinterface
`default_nettype wire

// File: sv/swad_ring.sv
`default_nettype none
module swad_ring import swad_pkg::*; #(
  parameter int WINDOW_MAX = 16,
  parameter int SAMPLE_BITS = 16,
  localparam int CNT_W = $clog2(WINDOW_MAX + 1),
  localparam int SUM_W = SAMPLE_BITS + CNT_W
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic [WLEN_W-1:0]             window_length,
  output unit_stat_t                         stat,
  output logic signed [SUM_W-1:0]            sum,
  output logic [CNT_W-1:0]                   win_cnt,
  output logic [CNT_W-1:0]                   equal_cnt
);

  localparam int HEAD_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int LW = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
  localparam logic [HEAD_W-1:0] LAST_IDX = HEAD_W'(WINDOW_MAX - 1);
  localparam logic [CNT_W-1:0]  WIN_FULL = CNT_W'(WINDOW_MAX);

  logic signed [SAMPLE_BITS-1:0] mem [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] rdata;
  logic signed [SAMPLE_BITS-1:0] cur;
  logic [HEAD_W-1:0]             head;
  logic [HEAD_W-1:0]             rp;
  logic [CNT_W-1:0]              fill;
  logic [CNT_W-1:0]              issue_left;
  logic                          pend;
  logic                          busy;
  logic [CNT_W-1:0]              fill_inc;
  logic [CNT_W-1:0]              len;
  logic [CNT_W-1:0]              cnt_new;
  logic [LW-1:0]                 wl_ext;

  function automatic logic [HEAD_W-1:0] ring_prev(input logic [HEAD_W-1:0] a);
    return (a == '0) ? LAST_IDX : a - 1'b1;
  endfunction

  assign wl_ext = LW'(window_length);

  always_comb begin
    if (window_length == '0) begin
      len = CNT_W'(1);
    end else if (wl_ext > LW'(WINDOW_MAX)) begin
      len = WIN_FULL;
    end else begin
      len = CNT_W'(wl_ext);
    end
    fill_inc = (fill == WIN_FULL) ? fill : fill + 1'b1;
    cnt_new  = (fill_inc < len) ? fill_inc : len;
  end

  // sample storage: the new sample goes in at head, older ones are read
  // walking backward; a read never hits the entry being written
  always_ff @(posedge clk) begin
    if (start) begin
      mem[head] <= sample;
    end
    rdata <= mem[rp];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      fill       <= '0;
      busy       <= 1'b0;
      pend       <= 1'b0;
      issue_left <= '0;
    end else begin
      pend <= busy && (issue_left != '0);
      if (start) begin
        head       <= (head == LAST_IDX) ? '0 : head + 1'b1;
        fill       <= fill_inc;
        busy       <= 1'b1;
        issue_left <= cnt_new - 1'b1;
      end else if (busy) begin
        if (issue_left != '0) begin
          issue_left <= issue_left - 1'b1;
        end else if (!pend) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // the current sample seeds the sum and the equal count
  always_ff @(posedge clk) begin
    if (start) begin
      rp        <= ring_prev(head);
      cur       <= sample;
      sum       <= SUM_W'(sample);
      equal_cnt <= CNT_W'(1);
      win_cnt   <= cnt_new;
    end else begin
      if (busy && (issue_left != '0)) begin
        rp <= ring_prev(rp);
      end
      if (pend) begin
        sum <= sum + SUM_W'(rdata);
        if (rdata == cur) begin
          equal_cnt <= equal_cnt + 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = busy && (issue_left == '0) && !pend;

endmodule
`default_nettype wire

// File: sv/swad_div.sv
`default_nettype none
module swad_div import swad_pkg::*; #(
  parameter int NUM_W = 29,
  parameter int DEN_W = 5,
  localparam int STEP_W = $clog2(NUM_W + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output unit_stat_t            stat,
  output logic [NUM_W-1:0]      quot
);

  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  dsr;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    rem_sub;
  logic              fits;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic              done;

  // restoring division, one quotient bit per cycle; quot doubles as the
  // dividend shift register
  always_comb begin
    rem_sh  = {rem, quot[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, dsr};
    fits    = !rem_sub[DEN_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= busy && (steps == STEP_W'(1));
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(NUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= num;
      rem  <= '0;
      dsr  <= den;
    end else if (busy) begin
      rem  <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quot <= {quot[NUM_W-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule
`default_nettype wire

// File: sv/sliding_window_anomaly_detector_core.sv
// Flow: a sample transaction starts the window scan, the scan sum goes to the restoring divider
// (NUM_W = SAMPLE_BITS + clog2(WINDOW_MAX+1) + 8, 29 with defaults), the saturated mean is
// registered, and the flag step loads the result into the output register.
// Throughput: one item at a time; the next is accepted while a result waits in
// the output register, and a still-waiting result holds the following item in its flag step.
// Reset (synchronous, active high) restores register defaults and clears all history.
`default_nettype none
module sliding_window_anomaly_detector_core import swad_pkg::*; #(
  parameter int WINDOW_MAX = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  swad_in_if.sink                    samples,
  swad_out_if.source                 results
);

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W = SAMPLE_BITS + CNT_W;
  localparam int NUM_W = SUM_W + FRAC_BITS;
  localparam int MW = (NUM_W + 1 > MEAN_W + 1) ? NUM_W + 1 : MEAN_W + 1;
  localparam int JW = (SAMPLE_BITS + 1 > JMP_W) ? SAMPLE_BITS + 1 : JMP_W;
  localparam int RW = (CNT_W > RPT_W) ? CNT_W : RPT_W;
  localparam logic signed [MW-1:0] MEAN_HI = MW'(2 ** (MEAN_W - 1) - 1);
  localparam logic signed [MW-1:0] MEAN_LO = ~MEAN_HI;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DIV, S_FLAG} state_t;

  state_t state;

  logic [WLEN_W-1:0] window_length;
  logic [MSL_W-1:0]  mean_shift_limit;
  logic [RPT_W-1:0]  repeat_limit;
  logic [JMP_W-1:0]  jump_limit;

  logic signed [SAMPLE_BITS-1:0] cur_sample;
  logic signed [SAMPLE_BITS-1:0] last_sample;
  logic                          have_last;
  logic signed [MEAN_W-1:0]      mean_reg;
  logic signed [MEAN_W-1:0]      last_mean;
  logic [TOTAL_W-1:0]            flag_total;
  logic [TOTAL_W-1:0]            flag_total_next;

  unit_stat_t              ring_st;
  unit_stat_t              div_st;
  logic signed [SUM_W-1:0] scan_sum;
  logic [CNT_W-1:0]        win_cnt;
  logic [CNT_W-1:0]        equal_cnt;
  logic                    ring_start;
  logic                    div_start;
  logic                    sum_neg;
  logic [SUM_W-1:0]        sum_mag;
  logic [NUM_W-1:0]        div_num;
  logic [NUM_W-1:0]        quot;
  logic signed [MW-1:0]    q_ext;
  logic signed [MW-1:0]    mean_wide;
  logic signed [MEAN_W-1:0] mean_sat;

  logic signed [MEAN_W:0]      mdiff;
  logic [MEAN_W:0]             mabs;
  logic signed [SAMPLE_BITS:0] sdiff;
  logic [SAMPLE_BITS:0]        sabs;
  logic                        f_mean;
  logic                        f_rep;
  logic                        f_jump;
  logic                        any_flag;
  logic                        out_load;

  assign samples.ready = (state == S_IDLE);
  assign ring_start    = samples.valid && samples.ready;
  assign div_start     = (state == S_SCAN) && ring_st.done;

  swad_ring #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_ring (
    .clk          (clk),
    .rst          (rst),
    .start        (ring_start),
    .sample       (samples.sample),
    .window_length(window_length),
    .stat         (ring_st),
    .sum          (scan_sum),
    .win_cnt      (win_cnt),
    .equal_cnt    (equal_cnt)
  );

  // mean magnitude is divided unsigned, sign restored after: truncates toward zero
  always_comb begin
    sum_neg = scan_sum[SUM_W-1];
    sum_mag = sum_neg ? SUM_W'(-scan_sum) : SUM_W'(scan_sum);
    div_num = {sum_mag, {FRAC_BITS{1'b0}}};
  end

  swad_div #(
    .NUM_W(NUM_W),
    .DEN_W(CNT_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (win_cnt),
    .stat (div_st),
    .quot (quot)
  );

  always_comb begin
    q_ext     = MW'(quot);
    mean_wide = sum_neg ? -q_ext : q_ext;
    if (mean_wide > MEAN_HI) begin
      mean_sat = MEAN_W'(MEAN_HI);
    end else if (mean_wide < MEAN_LO) begin
      mean_sat = MEAN_W'(MEAN_LO);
    end else begin
      mean_sat = MEAN_W'(mean_wide);
    end
  end

  always_comb begin
    mdiff    = (MEAN_W + 1)'(mean_reg) - (MEAN_W + 1)'(last_mean);
    mabs     = mdiff[MEAN_W] ? (MEAN_W + 1)'(-mdiff) : (MEAN_W + 1)'(mdiff);
    f_mean   = mabs > (MEAN_W + 1)'(mean_shift_limit);
    sdiff    = (SAMPLE_BITS + 1)'(cur_sample) - (SAMPLE_BITS + 1)'(last_sample);
    sabs     = sdiff[SAMPLE_BITS] ? (SAMPLE_BITS + 1)'(-sdiff) : (SAMPLE_BITS + 1)'(sdiff);
    f_jump   = have_last && (JW'(sabs) > JW'(jump_limit));
    f_rep    = RW'(equal_cnt) > RW'(repeat_limit);
    any_flag = f_mean || f_rep || f_jump;
    flag_total_next = flag_total + TOTAL_W'(any_flag);
    out_load = (state == S_FLAG) && (!results.valid || results.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length    <= WLEN_RESET;
      mean_shift_limit <= MSL_RESET;
      repeat_limit     <= RPT_RESET;
      jump_limit       <= JMP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WINDOW_LENGTH:    window_length    <= cfg_data[WLEN_W-1:0];
        REG_MEAN_SHIFT_LIMIT: mean_shift_limit <= cfg_data[MSL_W-1:0];
        REG_REPEAT_LIMIT:     repeat_limit     <= cfg_data[RPT_W-1:0];
        REG_JUMP_LIMIT:       jump_limit       <= cfg_data[JMP_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      results.valid <= 1'b0;
      flag_total    <= '0;
      last_mean     <= '0;
      last_sample   <= '0;
      have_last     <= 1'b0;
    end else begin
      if (results.valid && results.ready && !out_load) begin
        results.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (ring_start) begin
            cur_sample <= samples.sample;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (ring_st.done) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_st.done) begin
            mean_reg <= mean_sat;
            state    <= S_FLAG;
          end
        end
        S_FLAG: begin
          if (out_load) begin
            results.valid         <= 1'b1;
            results.anomaly       <= any_flag;
            results.mean_shift    <= f_mean;
            results.high_repeat   <= f_rep;
            results.jump          <= f_jump;
            results.window_mean   <= mean_reg;
            results.anomaly_total <= flag_total_next;
            flag_total            <= flag_total_next;
            last_mean             <= mean_reg;
            last_sample           <= cur_sample;
            have_last             <= 1'b1;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_scan_after_accept: assert property (@(posedge clk) disable iff (rst)
    ring_start |=> ring_st.busy)
    else $error("window scan did not start after a sample transaction");

  a_idle_units: assert property (@(posedge clk) disable iff (rst)
    samples.ready |-> (!ring_st.busy && !div_st.busy))
    else $error("input ready while scan or divider busy");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> (state == S_DIV))
    else $error("divider finished outside the divide state");

  a_equal_bounds: assert property (@(posedge clk) disable iff (rst)
    ring_st.done |-> (equal_cnt >= CNT_W'(1) && equal_cnt <= win_cnt))
    else $error("equal count outside window occupancy");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (out_load && any_flag) |=> (flag_total == $past(flag_total) + 32'd1))
    else $error("anomaly counter did not advance on a flagged item");

endmodule
`default_nettype wire
